// ===== hw/rtl/vpa_pkg.sv =====
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants for the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int unsigned ADDR_W            = 16;
  localparam int unsigned OWNER_SLOTS_DEF   = 32;
  localparam int unsigned HOLE_SLOTS_DEF    = 33;
  localparam logic [ADDR_W-1:0] POOL_DEF    = 16'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [2:0] ST_NO_FIT    = 3'd2;
  localparam logic [2:0] ST_TBL_FULL  = 3'd3;
  localparam logic [2:0] ST_NO_OWNER  = 3'd4;

  localparam logic [1:0] FIT_BEST  = 2'd0;
  localparam logic [1:0] FIT_WORST = 2'd1;
  localparam logic [1:0] FIT_FIRST = 2'd2;

  localparam logic REG_FIT  = 1'b0;
  localparam logic REG_POOL = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
  } hole_ent_t;

  typedef struct packed {
    logic [ADDR_W-1:0] id;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
  } owner_ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ASCAN,
    S_AWR,
    S_OSCAN,
    S_HSCAN,
    S_FWR,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/vpa_if.sv =====
// ----------------------------------------------------------------------------
// vpa_if
// Request and response channels of the allocator (valid/ready).
// ----------------------------------------------------------------------------
interface vpa_req_if import vpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] req_size;
  logic [ADDR_W-1:0] owner_id;

  modport source (output valid, output opcode, output req_size, output owner_id,
                  input ready);
  modport sink   (input valid, input opcode, input req_size, input owner_id,
                  output ready);
endinterface

interface vpa_rsp_if import vpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [ADDR_W-1:0] assigned_id;
  logic [ADDR_W-1:0] start_address;
  logic [ADDR_W-1:0] block_size;

  modport source (output valid, output status, output assigned_id,
                  output start_address, output block_size, input ready);
  modport sink   (input valid, input status, input assigned_id,
                  input start_address, input block_size, output ready);
endinterface

// ===== hw/rtl/variable_partition_allocator_core.sv =====
// ----------------------------------------------------------------------------
// variable_partition_allocator_core
// Memory pool allocator: best/worst/first fit placement, coalescing on free.
// ----------------------------------------------------------------------------
// Holes and owner records live in two single-port-read synchronous memories;
// each request walks them one entry per cycle. An allocate makes one
// hole-table pass plus write-back, a rejected allocate goes straight to its
// result, and a free does an owner search, then a hole pass to find both
// neighbors. The memory read port sets the pace. A finished result sits in
// the output register, so the next request is taken while it waits.
// No clearing pass is needed after reset.
module variable_partition_allocator_core
  import vpa_pkg::*;
#(
  parameter int unsigned OWNER_SLOTS = OWNER_SLOTS_DEF,
  parameter int unsigned HOLE_SLOTS  = HOLE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vpa_req_if.sink     in_chan,
  vpa_rsp_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned OIW = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
  localparam int unsigned HIW = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
  localparam int unsigned MW  = (OIW > HIW) ? OIW : HIW;
  localparam int unsigned CW  = MW + 1;
  localparam logic [CW-1:0] HOLE_END  = CW'(HOLE_SLOTS);
  localparam logic [CW-1:0] OWNER_END = CW'(OWNER_SLOTS);

  // memories
  hole_ent_t  hole_mem [HOLE_SLOTS];
  owner_ent_t own_mem  [OWNER_SLOTS];
  hole_ent_t  hole_rd_r;
  owner_ent_t own_rd_r;
  logic [HIW-1:0] hole_ra;
  logic [OIW-1:0] own_ra;
  logic           hole_we;
  logic [HIW-1:0] hole_wa;
  hole_ent_t      hole_wd;
  logic           own_we;
  logic [OIW-1:0] own_wa;
  owner_ent_t     own_wd;

  always_ff @(posedge clk) begin
    if (hole_we) begin
      hole_mem[hole_wa] <= hole_wd;
    end
    hole_rd_r <= hole_mem[hole_ra];
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      own_mem[own_wa] <= own_wd;
    end
    own_rd_r <= own_mem[own_ra];
  end

  // control state
  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      ridx_r;
  logic [ADDR_W-1:0]  size_r, size_nxt;
  logic [ADDR_W-1:0]  oid_r, oid_nxt;
  logic [OIW-1:0]     slot_r, slot_nxt;
  logic [ADDR_W-1:0]  id_ctr_r, id_ctr_nxt;
  logic               found_r, found_nxt;
  logic [HIW-1:0]     pk_idx_r, pk_idx_nxt;
  logic [ADDR_W-1:0]  pk_start_r, pk_start_nxt;
  logic [ADDR_W-1:0]  pk_len_r, pk_len_nxt;
  logic               bf_r, bf_nxt;
  logic [HIW-1:0]     bf_idx_r, bf_idx_nxt;
  logic [ADDR_W-1:0]  bf_start_r, bf_start_nxt;
  logic [ADDR_W-1:0]  bf_len_r, bf_len_nxt;
  logic               af_r, af_nxt;
  logic [HIW-1:0]     af_idx_r, af_idx_nxt;
  logic [ADDR_W-1:0]  af_len_r, af_len_nxt;
  logic [HOLE_SLOTS-1:0]  hole_valid_r, hole_valid_nxt;
  logic [OWNER_SLOTS-1:0] owner_valid_r, owner_valid_nxt;
  logic               hole0_fresh_r, hole0_fresh_nxt;
  logic [1:0]         fit_mode_r, fit_mode_nxt;
  logic [ADDR_W-1:0]  pool_size_r, pool_size_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         res_status_r, res_status_nxt, out_status_r;
  logic [ADDR_W-1:0]  res_id_r, res_id_nxt, out_id_r;
  logic [ADDR_W-1:0]  res_start_r, res_start_nxt, out_start_r;
  logic [ADDR_W-1:0]  res_len_r, res_len_nxt, out_len_r;

  // free-slot searches over valid bits
  logic             own_free_any;
  logic [OIW-1:0]   own_free_idx;
  logic             hole_free_any;
  logic [HIW-1:0]   hole_free_idx;

  always_comb begin
    own_free_any = 1'b0;
    own_free_idx = '0;
    for (int i = OWNER_SLOTS - 1; i >= 0; i--) begin
      if (!owner_valid_r[i]) begin
        own_free_any = 1'b1;
        own_free_idx = OIW'(i);
      end
    end
    hole_free_any = 1'b0;
    hole_free_idx = '0;
    for (int i = HOLE_SLOTS - 1; i >= 0; i--) begin
      if (!hole_valid_r[i]) begin
        hole_free_any = 1'b1;
        hole_free_idx = HIW'(i);
      end
    end
  end

  // hole entry 0 reads as the whole pool until first written
  hole_ent_t hd;
  always_comb begin
    hd = hole_rd_r;
    if (ridx_r[HIW-1:0] == '0 && hole0_fresh_r) begin
      hd.start = '0;
      hd.len   = pool_size_r;
    end
  end

  logic [HIW-1:0]  rh;
  logic [OIW-1:0]  ro;
  logic [ADDR_W:0] hole_end_w;
  logic [ADDR_W:0] blk_end_w;
  logic            cand;
  logic            better;
  logic            cfg_wr;
  logic            in_xfer;
  logic            out_load;

  assign rh         = ridx_r[HIW-1:0];
  assign ro         = ridx_r[OIW-1:0];
  assign hole_end_w = {1'b0, hd.start} + {1'b0, hd.len};
  assign blk_end_w  = {1'b0, pk_start_r} + {1'b0, pk_len_r};
  assign cand       = hole_valid_r[rh] && (hd.len >= size_r);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign in_xfer    = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign hole_ra    = (cnt_r < HOLE_END)  ? cnt_r[HIW-1:0] : '0;
  assign own_ra     = (cnt_r < OWNER_END) ? cnt_r[OIW-1:0] : '0;

  always_comb begin
    unique case (fit_mode_r)
      FIT_WORST: better = (hd.len > pk_len_r) ||
                          (hd.len == pk_len_r && hd.start < pk_start_r);
      FIT_FIRST: better = hd.start < pk_start_r;
      default:   better = (hd.len < pk_len_r) ||
                          (hd.len == pk_len_r && hd.start < pk_start_r);
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    size_nxt        = size_r;
    oid_nxt         = oid_r;
    slot_nxt        = slot_r;
    id_ctr_nxt      = id_ctr_r;
    found_nxt       = found_r;
    pk_idx_nxt      = pk_idx_r;
    pk_start_nxt    = pk_start_r;
    pk_len_nxt      = pk_len_r;
    bf_nxt          = bf_r;
    bf_idx_nxt      = bf_idx_r;
    bf_start_nxt    = bf_start_r;
    bf_len_nxt      = bf_len_r;
    af_nxt          = af_r;
    af_idx_nxt      = af_idx_r;
    af_len_nxt      = af_len_r;
    hole_valid_nxt  = hole_valid_r;
    owner_valid_nxt = owner_valid_r;
    hole0_fresh_nxt = hole0_fresh_r;
    fit_mode_nxt    = fit_mode_r;
    pool_size_nxt   = pool_size_r;
    res_status_nxt  = res_status_r;
    res_id_nxt      = res_id_r;
    res_start_nxt   = res_start_r;
    res_len_nxt     = res_len_r;
    hole_we         = 1'b0;
    hole_wa         = '0;
    hole_wd         = '0;
    own_we          = 1'b0;
    own_wa          = '0;
    own_wd          = '0;
    out_load        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          size_nxt  = in_chan.req_size;
          oid_nxt   = in_chan.owner_id;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          bf_nxt    = 1'b0;
          af_nxt    = 1'b0;
          res_start_nxt = '0;
          res_len_nxt   = '0;
          if (in_chan.opcode == OP_FREE) begin
            state_nxt = S_OSCAN;
          end else if (in_chan.req_size == '0 || in_chan.req_size > pool_size_r ||
                       !(|hole_valid_r)) begin
            res_status_nxt = ST_BAD_SIZE;
            res_id_nxt     = '0;
            state_nxt      = S_DONE;
          end else if (!own_free_any) begin
            res_status_nxt = ST_TBL_FULL;
            res_id_nxt     = '0;
            state_nxt      = S_DONE;
          end else begin
            slot_nxt   = own_free_idx;
            id_ctr_nxt = id_ctr_r + 1'b1;
            state_nxt  = S_ASCAN;
          end
        end
      end

      S_ASCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0 && cand && (!found_r || better)) begin
          found_nxt    = 1'b1;
          pk_idx_nxt   = rh;
          pk_start_nxt = hd.start;
          pk_len_nxt   = hd.len;
        end
        if (cnt_r == HOLE_END) begin
          state_nxt = S_AWR;
        end
      end

      S_AWR: begin
        res_id_nxt = id_ctr_r;
        if (!found_r) begin
          res_status_nxt = ST_NO_FIT;
        end else begin
          own_we   = 1'b1;
          own_wa   = slot_r;
          own_wd   = '{id: id_ctr_r, start: pk_start_r, len: size_r};
          owner_valid_nxt[slot_r] = 1'b1;
          if (pk_len_r == size_r) begin
            hole_valid_nxt[pk_idx_r] = 1'b0;
          end else begin
            hole_we = 1'b1;
            hole_wa = pk_idx_r;
            hole_wd = '{start: pk_start_r + size_r, len: pk_len_r - size_r};
          end
          res_status_nxt = ST_OK;
          res_start_nxt  = pk_start_r;
          res_len_nxt    = size_r;
        end
        state_nxt = S_DONE;
      end

      S_OSCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0 && !found_r && owner_valid_r[ro] && own_rd_r.id == oid_r) begin
          found_nxt    = 1'b1;
          slot_nxt     = ro;
          pk_start_nxt = own_rd_r.start;
          pk_len_nxt   = own_rd_r.len;
        end
        // last entry is compared in this same cycle
        if (cnt_r == OWNER_END) begin
          cnt_nxt    = '0;
          res_id_nxt = oid_r;
          if (!found_nxt) begin
            res_status_nxt = ST_NO_OWNER;
            state_nxt      = S_DONE;
          end else begin
            owner_valid_nxt[slot_nxt] = 1'b0;
            state_nxt = S_HSCAN;
          end
        end
      end

      S_HSCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0 && hole_valid_r[rh]) begin
          if (!bf_r && hole_end_w == {1'b0, pk_start_r}) begin
            bf_nxt       = 1'b1;
            bf_idx_nxt   = rh;
            bf_start_nxt = hd.start;
            bf_len_nxt   = hd.len;
          end
          if (!af_r && {1'b0, hd.start} == blk_end_w) begin
            af_nxt     = 1'b1;
            af_idx_nxt = rh;
            af_len_nxt = hd.len;
          end
        end
        if (cnt_r == HOLE_END) begin
          state_nxt = S_FWR;
        end
      end

      S_FWR: begin
        if (bf_r) begin
          hole_we = 1'b1;
          hole_wa = bf_idx_r;
          hole_wd = '{start: bf_start_r,
                      len: bf_len_r + pk_len_r + (af_r ? af_len_r : '0)};
          if (af_r) begin
            hole_valid_nxt[af_idx_r] = 1'b0;
          end
        end else if (af_r) begin
          hole_we = 1'b1;
          hole_wa = af_idx_r;
          hole_wd = '{start: pk_start_r, len: af_len_r + pk_len_r};
        end else if (hole_free_any) begin
          hole_we = 1'b1;
          hole_wa = hole_free_idx;
          hole_wd = '{start: pk_start_r, len: pk_len_r};
          hole_valid_nxt[hole_free_idx] = 1'b1;
        end
        res_status_nxt = ST_OK;
        res_start_nxt  = pk_start_r;
        res_len_nxt    = pk_len_r;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (hole_we && hole_wa == '0) begin
      hole0_fresh_nxt = 1'b0;
    end

    // register writes are to arrive only while idle; the block does not enforce it
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_FIT: fit_mode_nxt = cfg_pwdata[1:0];
        REG_POOL: begin
          if (cfg_pwdata[ADDR_W-1:0] != '0 && !(|owner_valid_r)) begin
            pool_size_nxt   = cfg_pwdata[ADDR_W-1:0];
            hole_valid_nxt  = HOLE_SLOTS'(1);
            hole0_fresh_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end

    out_valid_nxt = (out_valid_r && !out_chan.ready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      id_ctr_r      <= '0;
      hole_valid_r  <= HOLE_SLOTS'(1);
      owner_valid_r <= '0;
      hole0_fresh_r <= 1'b1;
      fit_mode_r    <= FIT_BEST;
      pool_size_r   <= POOL_DEF;
      out_valid_r   <= 1'b0;
      found_r       <= 1'b0;
      bf_r          <= 1'b0;
      af_r          <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      id_ctr_r      <= id_ctr_nxt;
      hole_valid_r  <= hole_valid_nxt;
      owner_valid_r <= owner_valid_nxt;
      hole0_fresh_r <= hole0_fresh_nxt;
      fit_mode_r    <= fit_mode_nxt;
      pool_size_r   <= pool_size_nxt;
      out_valid_r   <= out_valid_nxt;
      found_r       <= found_nxt;
      bf_r          <= bf_nxt;
      af_r          <= af_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r       <= cnt_r;
    size_r       <= size_nxt;
    oid_r        <= oid_nxt;
    slot_r       <= slot_nxt;
    pk_idx_r     <= pk_idx_nxt;
    pk_start_r   <= pk_start_nxt;
    pk_len_r     <= pk_len_nxt;
    bf_idx_r     <= bf_idx_nxt;
    bf_start_r   <= bf_start_nxt;
    bf_len_r     <= bf_len_nxt;
    af_idx_r     <= af_idx_nxt;
    af_len_r     <= af_len_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_start_r  <= res_start_nxt;
    res_len_r    <= res_len_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_start_r  <= res_start_r;
      out_len_r    <= res_len_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.assigned_id   = out_id_r;
  assign out_chan.start_address = out_start_r;
  assign out_chan.block_size    = out_len_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_POOL) ? {16'd0, pool_size_r}
                                                 : {30'd0, fit_mode_r};

endmodule
